### rtl/swt_pkg.sv
// ----------------------------------------------------------------------------
// swt_pkg
// shared types, constants and the microcode program of the sorted word table
// ----------------------------------------------------------------------------
package swt_pkg;

    localparam int DEF_TABLE_DEPTH = 1024;
    localparam int DEF_MAX_LEN     = 32;

    localparam int CHAR_W  = 8;
    localparam int INDEX_W = 10;
    localparam int SIZE_W  = 11;
    localparam int STEP_W  = 4;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [STEP_W-1:0] {
        ST_IDLE,
        ST_PUT_CHAR,
        ST_PUT_TERM,
        ST_INIT,
        ST_PROBE,
        ST_ISSUE,
        ST_COMPARE,
        ST_CHECK,
        ST_REPORT
    } step_t;

    typedef enum logic [2:0] {
        A_NONE,
        A_PUT_CHAR,
        A_PUT_TERM,
        A_INIT,
        A_PROBE,
        A_ISSUE,
        A_COMPARE,
        A_REPORT
    } act_t;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_START,
        C_NOT_END,
        C_LOAD,
        C_EMPTY,
        C_MORE_CHARS,
        C_MISS
    } cond_t;

    typedef struct packed {
        logic  ready;
        act_t  act;
        cond_t cond;
        step_t target;
    } ucode_t;

    function automatic ucode_t ucode_rom(input step_t step);
        ucode_t word;
        word = '{ready: 1'b0, act: A_NONE, cond: C_ALWAYS, target: ST_IDLE};
        unique case (step)
            ST_IDLE:     word = '{1'b1, A_NONE,     C_NO_START,   ST_IDLE};
            ST_PUT_CHAR: word = '{1'b0, A_PUT_CHAR, C_NOT_END,    ST_IDLE};
            ST_PUT_TERM: word = '{1'b0, A_PUT_TERM, C_LOAD,       ST_IDLE};
            ST_INIT:     word = '{1'b0, A_INIT,     C_NEVER,      ST_IDLE};
            ST_PROBE:    word = '{1'b0, A_PROBE,    C_EMPTY,      ST_REPORT};
            ST_ISSUE:    word = '{1'b0, A_ISSUE,    C_NEVER,      ST_IDLE};
            ST_COMPARE:  word = '{1'b0, A_COMPARE,  C_MORE_CHARS, ST_COMPARE};
            ST_CHECK:    word = '{1'b0, A_NONE,     C_MISS,       ST_PROBE};
            ST_REPORT:   word = '{1'b0, A_REPORT,   C_ALWAYS,     ST_IDLE};
            default:     word = '{1'b0, A_NONE,     C_ALWAYS,     ST_IDLE};
        endcase
        return word;
    endfunction

endpackage

### rtl/swt_ram.sv
// ----------------------------------------------------------------------------
// swt_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module swt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] store_mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_mem[waddr] <= wdata;
        end
        rdata_reg <= store_mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/sorted_word_table_binary_search_top.sv
// ----------------------------------------------------------------------------
// sorted_word_table_binary_search_top
// sorted word table with binary search lookup, run by a microcoded sequencer
// ----------------------------------------------------------------------------
// channel  direction  handshake               payload
// input    in         start / busy            operation, char_code, word_end
// result   out        done strobe, no stall   found, match_index, too_long
// config   in         cfg_we                  cfg_wdata (search size)
//
// a character that does not end a word is stored and the block goes idle;
// a load word end also writes the terminator; a query word end writes it,
// then searches, comparing up to MAX_LEN characters per probe a byte at a
// time through the read port, over up to clog2(TABLE_DEPTH)+1 probes
// reset clears control state only; the stores need no clearing pass
// done is high for one cycle per query word; the receiver cannot stall
// ----------------------------------------------------------------------------
module sorted_word_table_binary_search_top
    import swt_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int MAX_LEN     = DEF_MAX_LEN
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               operation,
    input  logic [CHAR_W-1:0]  char_code,
    input  logic               word_end,
    input  logic               cfg_we,
    input  logic [SIZE_W-1:0]  cfg_wdata,
    output logic               done,
    output logic               found,
    output logic [INDEX_W-1:0] match_index,
    output logic               too_long
);

    localparam int PW         = $clog2(MAX_LEN);
    localparam int AWE        = $clog2(TABLE_DEPTH);
    localparam int EW         = $clog2(TABLE_DEPTH + 1);
    localparam int WORD_DEPTH = TABLE_DEPTH << PW;

    localparam logic [PW-1:0] POS_LAST = PW'(MAX_LEN - 1);
    localparam logic [PW:0]   I_END    = (PW+1)'(MAX_LEN);
    localparam logic [EW-1:0] ENT_FULL = EW'(TABLE_DEPTH);

    step_t  step_reg, step_next;
    ucode_t ctl;
    logic   jump;

    logic              op_reg, end_reg;
    logic [CHAR_W-1:0] ch_reg;
    logic [SIZE_W-1:0] search_size_reg;

    logic [EW-1:0]  load_entry_reg, load_entry_next;
    logic [PW-1:0]  load_pos_reg, load_pos_next;
    logic [PW-1:0]  query_pos_reg, query_pos_next;
    logic           overflow_reg, overflow_next;
    logic [EW-1:0]  lo_reg, lo_next, hi_reg, hi_next;
    logic [AWE-1:0] mid_reg, mid_next;
    logic [PW:0]    i_reg, i_next;
    logic           found_reg, found_next;

    logic [EW-1:0] entries;
    logic [EW:0]   mid_sum;
    logic          table_full, char_same, more_chars;

    logic                    w_we, q_we;
    logic [AWE+PW-1:0]       w_waddr, w_raddr;
    logic [PW-1:0]           q_waddr;
    logic [CHAR_W-1:0]       w_wdata, q_wdata, w_rdata, q_rdata;

    swt_ram #(.WIDTH(CHAR_W), .DEPTH(WORD_DEPTH)) u_word_ram (
        .clk   (clk),
        .we    (w_we),
        .waddr (w_waddr),
        .wdata (w_wdata),
        .raddr (w_raddr),
        .rdata (w_rdata)
    );

    swt_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_LEN)) u_query_ram (
        .clk   (clk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (q_wdata),
        .raddr (i_reg[PW-1:0]),
        .rdata (q_rdata)
    );

    assign ctl        = ucode_rom(step_reg);
    assign busy       = !ctl.ready;
    assign table_full = (load_entry_reg == ENT_FULL);
    assign w_raddr    = {mid_reg, i_reg[PW-1:0]};
    assign mid_sum    = {1'b0, lo_reg} + {1'b0, hi_reg} - (EW+1)'(1);
    assign char_same  = (w_rdata == q_rdata);
    assign more_chars = char_same && (w_rdata != '0) && (i_reg != I_END);

    assign done        = (ctl.act == A_REPORT);
    assign found       = found_reg;
    assign match_index = found_reg ? INDEX_W'(mid_reg) : '0;
    assign too_long    = overflow_reg;

    always_comb
    begin
        if (32'(search_size_reg) > 32'(TABLE_DEPTH))
        begin
            entries = ENT_FULL;
        end
        else
        begin
            entries = EW'(search_size_reg);
        end
    end

    // sequencer
    always_comb
    begin
        unique case (ctl.cond)
            C_NEVER:      jump = 1'b0;
            C_ALWAYS:     jump = 1'b1;
            C_NO_START:   jump = !start;
            C_NOT_END:    jump = !end_reg;
            C_LOAD:       jump = (op_reg == OP_LOAD);
            C_EMPTY:      jump = (lo_reg >= hi_reg);
            C_MORE_CHARS: jump = more_chars;
            C_MISS:       jump = !found_reg;
            default:      jump = 1'b0;
        endcase
        if (jump)
        begin
            step_next = ctl.target;
        end
        else
        begin
            step_next = step_t'(STEP_W'(step_reg) + STEP_W'(1));
        end
    end

    // datapath
    always_comb
    begin
        load_entry_next = load_entry_reg;
        load_pos_next   = load_pos_reg;
        query_pos_next  = query_pos_reg;
        overflow_next   = overflow_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        i_next          = i_reg;
        found_next      = found_reg;
        w_we            = 1'b0;
        w_waddr         = {load_entry_reg[AWE-1:0], load_pos_reg};
        w_wdata         = ch_reg;
        q_we            = 1'b0;
        q_waddr         = query_pos_reg;
        q_wdata         = ch_reg;
        unique case (ctl.act)
            A_PUT_CHAR:
            begin
                if (op_reg == OP_LOAD)
                begin
                    if (!table_full && (load_pos_reg != POS_LAST))
                    begin
                        w_we          = 1'b1;
                        load_pos_next = load_pos_reg + PW'(1);
                    end
                end
                else if (query_pos_reg != POS_LAST)
                begin
                    q_we           = 1'b1;
                    query_pos_next = query_pos_reg + PW'(1);
                end
                else
                begin
                    overflow_next = 1'b1;
                end
            end
            A_PUT_TERM:
            begin
                w_wdata = '0;
                q_wdata = '0;
                if (op_reg == OP_LOAD)
                begin
                    if (!table_full)
                    begin
                        w_we            = 1'b1;
                        load_entry_next = load_entry_reg + EW'(1);
                        load_pos_next   = '0;
                    end
                end
                else
                begin
                    q_we = 1'b1;
                end
            end
            A_INIT:
            begin
                lo_next    = '0;
                hi_next    = entries;
                found_next = 1'b0;
            end
            A_PROBE:
            begin
                mid_next = mid_sum[AWE:1];
                i_next   = '0;
            end
            A_ISSUE:
            begin
                i_next = i_reg + (PW+1)'(1);
            end
            A_COMPARE:
            begin
                i_next = i_reg + (PW+1)'(1);
                if (!more_chars)
                begin
                    if (char_same)
                    begin
                        found_next = 1'b1;
                    end
                    else if (w_rdata < q_rdata)
                    begin
                        lo_next = EW'(mid_reg) + EW'(1);
                    end
                    else
                    begin
                        hi_next = EW'(mid_reg);
                    end
                end
            end
            A_REPORT:
            begin
                query_pos_next = '0;
                overflow_next  = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg        <= ST_IDLE;
            search_size_reg <= '0;
            load_entry_reg  <= '0;
            load_pos_reg    <= '0;
            query_pos_reg   <= '0;
            overflow_reg    <= 1'b0;
            found_reg       <= 1'b0;
        end
        else
        begin
            step_reg       <= step_next;
            load_entry_reg <= load_entry_next;
            load_pos_reg   <= load_pos_next;
            query_pos_reg  <= query_pos_next;
            overflow_reg   <= overflow_next;
            found_reg      <= found_next;
            if (cfg_we)
            begin
                search_size_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        mid_reg <= mid_next;
        i_reg   <= i_next;
        if (start && !busy)
        begin
            op_reg  <= operation;
            ch_reg  <= char_code;
            end_reg <= word_end;
        end
    end

    // checks
    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy
    ) else $error("busy low after accepted word");

    a_done_while_busy: assert property (
        @(posedge clk) disable iff (!rst_n)
        done |-> (busy && $past(busy))
    ) else $error("result without search");

    a_probe_in_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        (step_reg == ST_COMPARE) |-> ((EW'(mid_reg) >= lo_reg) && (EW'(mid_reg) < hi_reg))
    ) else $error("probe outside search window");

    a_load_pos_bound: assert property (
        @(posedge clk) disable iff (!rst_n)
        (load_pos_reg <= POS_LAST) && (query_pos_reg <= POS_LAST)
    ) else $error("character position past slot end");

endmodule
